// ===== rtl/mpe_pkg.sv =====
// ----------------------------------------------------------------------------
// mpe_pkg: shared types and constants of the matrix power engine
// Field widths of the stream payloads, the operation codes carried in
// in_tuser, and the tag that travels with each product term.
// ----------------------------------------------------------------------------
package mpe_pkg;

  // Operation codes carried in in_tuser.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  // Payload field widths.
  localparam int ROW_W = 3;
  localparam int COL_W = 3;
  localparam int VAL_W = 32;
  localparam int EXP_W = 63;

  // Packed stream widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - ROW_W - COL_W - VAL_W;

  // Control that accompanies one product term through the multiply pipeline.
  typedef struct packed {
    logic valid;
    logic first;  // first term of a dot product: restart the accumulator
    logic last;   // last term: the sum is complete and is written out
  } mac_tag_t;

endpackage

// ===== rtl/mpe_ram.sv =====
// ----------------------------------------------------------------------------
// mpe_ram: generic synchronous RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module mpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  output logic [WIDTH-1:0]                           rdata_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                           rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/mpe_mac.sv =====
// ----------------------------------------------------------------------------
// mpe_mac: pipelined multiply-accumulate unit
// Takes one product term per cycle, splits the multiply into half-width
// partial products, and writes each finished dot product to the scratch store.
// ----------------------------------------------------------------------------
module mpe_mac #(
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mpe_pkg::mac_tag_t tag_in,
  input  logic [AW-1:0]     addr_in,
  input  logic [WIDTH-1:0]  a_in,
  input  logic [WIDTH-1:0]  b_in,
  output logic              busy,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [WIDTH-1:0]  wr_data
);

  localparam int HW = (WIDTH + 1) / 2;  // low half
  localparam int LW = WIDTH - HW;       // high half
  localparam int PW = 2 * HW;

  logic [HW-1:0] a_lo, b_lo;
  logic [LW-1:0] a_hi, b_hi;

  mpe_pkg::mac_tag_t s1_tag_r, s2_tag_r;
  logic [AW-1:0]     s1_addr_r, s2_addr_r;
  logic [PW-1:0]     pll_r;
  logic [LW-1:0]     pc1_r, pc2_r;
  logic [WIDTH-1:0]  prod_r;
  logic [WIDTH-1:0]  acc_r;
  logic [WIDTH-1:0]  sum;

  assign a_lo = a_in[HW-1:0];
  assign b_lo = b_in[HW-1:0];
  assign a_hi = a_in[WIDTH-1:HW];
  assign b_hi = b_in[WIDTH-1:HW];

  // Only the low WIDTH bits of the product matter, so the high-by-high
  // term drops out and the cross terms keep just their low bits.
  assign sum = (s2_tag_r.first ? '0 : acc_r) + prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r <= '0;
      s2_tag_r <= '0;
    end else begin
      s1_tag_r <= tag_in;
      s2_tag_r <= s1_tag_r;
    end
    s1_addr_r <= addr_in;
    pll_r     <= PW'(a_lo) * PW'(b_lo);
    pc1_r     <= LW'(a_lo * HW'(b_hi));
    pc2_r     <= LW'(HW'(a_hi) * b_lo);
    s2_addr_r <= s1_addr_r;
    prod_r    <= WIDTH'(pll_r) + (WIDTH'(LW'(pc1_r + pc2_r)) << HW);
    if (s2_tag_r.valid) begin
      acc_r <= sum;
    end
  end

  assign busy    = s1_tag_r.valid | s2_tag_r.valid;
  assign wr_en   = s2_tag_r.valid & s2_tag_r.last;
  assign wr_addr = s2_addr_r;
  assign wr_data = sum;

endmodule

// ===== rtl/matrix_power_engine_unit.sv =====
// ----------------------------------------------------------------------------
// matrix_power_engine_unit: matrix power by square-and-multiply
// Loads elements of a DIM x DIM base matrix, raises it to a given power with
// wrapping WIDTH-bit arithmetic, and streams the result out row by row.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | tdata fields (LSB first)              | tuser  | tlast
//  --------+-----------+---------------------------------------+--------+-------------
//  in_     | slave     | row, col, element value, exponent     | opcode | -
//  out_    | master    | row, col, value                       | -      | last element
//
//  A load item writes one base element. A run sets the result to identity,
//  then per exponent bit does up to two multiplies, then emits each element.
//  The single multiply-accumulate pipeline, fed one term per cycle from the
//  stores' read ports, paces the multiplies. Reset is synchronous and leaves
//  the block idle. The input is not taken while a run is under way; a stalled
//  output holds the emit walk.
//
module matrix_power_engine_unit #(
  parameter int DIM   = 8,
  parameter int WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // row [2:0], col [5:3], element value [37:6], exponent [100:38]
  input  logic [mpe_pkg::IN_TDATA_W-1:0]     in_tdata,
  // opcode [0]
  input  logic                               in_tuser,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // row [2:0], col [5:3], value [37:6]
  output logic [mpe_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready
);

  localparam int CELLS = DIM * DIM;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int IW    = (DIM > 1) ? $clog2(DIM) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(DIM - 1);

  localparam int ROW_W = mpe_pkg::ROW_W;
  localparam int COL_W = mpe_pkg::COL_W;
  localparam int VAL_W = mpe_pkg::VAL_W;
  localparam int EXP_W = mpe_pkg::EXP_W;
  localparam int COL_LSB = ROW_W;
  localparam int VAL_LSB = COL_LSB + COL_W;
  localparam int EXP_LSB = VAL_LSB + VAL_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_CHECK,
    S_MUL,
    S_DRAIN,
    S_COPY,
    S_COPY_END,
    S_SHIFT,
    S_EMIT_RD,
    S_EMIT_WAIT
  } state_t;

  // Input fields.
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] in_col;
  logic [VAL_W-1:0] in_value;
  logic [EXP_W-1:0] in_exp;

  assign in_row   = in_tdata[ROW_W-1:0];
  assign in_col   = in_tdata[COL_LSB +: COL_W];
  assign in_value = in_tdata[VAL_LSB +: VAL_W];
  assign in_exp   = in_tdata[EXP_LSB +: EXP_W];

  // Control and output registers.
  state_t            state_r, state_nxt;
  logic [EXP_W-1:0]  exp_r, exp_nxt;
  logic              sq_r, sq_nxt;  // multiply is base*base into base
  logic [IW-1:0]     r_r, r_nxt, c_r, c_nxt, k_r, k_nxt;
  mpe_pkg::mac_tag_t tag_r, tag_nxt;
  logic [AW-1:0]     tag_addr_r, tag_addr_nxt;
  logic              copy_v_r, copy_v_nxt;
  logic [AW-1:0]     copy_addr_r, copy_addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [VAL_W-1:0]  out_value_r, out_value_nxt;
  logic              out_last_r, out_last_nxt;

  logic r_last, c_last, k_last;
  logic [AW-1:0] rc_addr, rk_addr, kc_addr, load_addr;
  logic load_ok, emit_load;

  // Store ports.
  logic             b_we, r_we;
  logic [AW-1:0]    b_waddr, r_waddr, r_raddr;
  logic [WIDTH-1:0] b_wdata, r_wdata;
  logic [WIDTH-1:0] b_rdata_a, b_rdata_b, r_rdata_a, s_rdata_a;

  // Multiply-accumulate unit.
  logic             mac_busy, mac_wr_en;
  logic [AW-1:0]    mac_wr_addr;
  logic [WIDTH-1:0] mac_wr_data, mac_a;

  assign r_last = (r_r == LAST_IDX);
  assign c_last = (c_r == LAST_IDX);
  assign k_last = (k_r == LAST_IDX);

  assign rc_addr   = AW'(r_r) * AW'(DIM) + AW'(c_r);
  assign rk_addr   = AW'(r_r) * AW'(DIM) + AW'(k_r);
  assign kc_addr   = AW'(k_r) * AW'(DIM) + AW'(c_r);
  assign load_addr = AW'(in_row) * AW'(DIM) + AW'(in_col);
  assign load_ok   = (4'(in_row) < 4'(DIM)) && (4'(in_col) < 4'(DIM));

  assign in_tready = (state_r == S_IDLE);
  assign emit_load = (state_r == S_EMIT_WAIT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    exp_nxt       = exp_r;
    sq_nxt        = sq_r;
    r_nxt         = r_r;
    c_nxt         = c_r;
    k_nxt         = k_r;
    tag_nxt       = '0;
    tag_addr_nxt  = rc_addr;
    copy_v_nxt    = 1'b0;
    copy_addr_nxt = rc_addr;
    out_valid_nxt = out_valid_r && !out_tready;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tuser == mpe_pkg::OP_RUN) begin
          exp_nxt   = in_exp;
          r_nxt     = '0;
          c_nxt     = '0;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        c_nxt = c_last ? '0 : c_r + IW'(1);
        if (c_last) begin
          r_nxt = r_last ? '0 : r_r + IW'(1);
          if (r_last) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        r_nxt = '0;
        c_nxt = '0;
        k_nxt = '0;
        if (exp_r == '0) begin
          state_nxt = S_EMIT_RD;
        end else if (exp_r[0]) begin
          sq_nxt    = 1'b0;
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_SHIFT;
        end
      end
      S_MUL: begin
        tag_nxt.valid = 1'b1;
        tag_nxt.first = (k_r == '0);
        tag_nxt.last  = k_last;
        k_nxt = k_last ? '0 : k_r + IW'(1);
        if (k_last) begin
          c_nxt = c_last ? '0 : c_r + IW'(1);
          if (c_last) begin
            r_nxt = r_last ? '0 : r_r + IW'(1);
            if (r_last) begin
              state_nxt = S_DRAIN;
            end
          end
        end
      end
      S_DRAIN: begin
        // The last dot product must be in the scratch store before copying.
        if (!mac_busy && !tag_r.valid) begin
          r_nxt     = '0;
          c_nxt     = '0;
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        copy_v_nxt = 1'b1;
        c_nxt = c_last ? '0 : c_r + IW'(1);
        if (c_last) begin
          r_nxt = r_last ? '0 : r_r + IW'(1);
          if (r_last) begin
            state_nxt = S_COPY_END;
          end
        end
      end
      S_COPY_END: begin
        state_nxt = sq_r ? S_CHECK : S_SHIFT;
      end
      S_SHIFT: begin
        exp_nxt = exp_r >> 1;
        r_nxt   = '0;
        c_nxt   = '0;
        k_nxt   = '0;
        // The base is squared only while exponent bits remain.
        if ((exp_r >> 1) != '0) begin
          sq_nxt    = 1'b1;
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        state_nxt = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (emit_load) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = ROW_W'(r_r);
          out_col_nxt   = COL_W'(c_r);
          out_value_nxt = VAL_W'(r_rdata_a);
          out_last_nxt  = r_last && c_last;
          c_nxt = c_last ? '0 : c_r + IW'(1);
          if (c_last) begin
            r_nxt = r_last ? '0 : r_r + IW'(1);
          end
          state_nxt = (r_last && c_last) ? S_IDLE : S_EMIT_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      exp_r       <= '0;
      sq_r        <= 1'b0;
      r_r         <= '0;
      c_r         <= '0;
      k_r         <= '0;
      tag_r       <= '0;
      copy_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      exp_r       <= exp_nxt;
      sq_r        <= sq_nxt;
      r_r         <= r_nxt;
      c_r         <= c_nxt;
      k_r         <= k_nxt;
      tag_r       <= tag_nxt;
      copy_v_r    <= copy_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    tag_addr_r  <= tag_addr_nxt;
    copy_addr_r <= copy_addr_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Base store writes: element loads, the squared base, and the final result
  // copied back as it is emitted.
  always_comb begin
    b_we    = 1'b0;
    b_waddr = load_addr;
    b_wdata = WIDTH'(in_value);
    if (in_tvalid && in_tready && in_tuser == mpe_pkg::OP_LOAD && load_ok) begin
      b_we = 1'b1;
    end else if (copy_v_r && sq_r) begin
      b_we    = 1'b1;
      b_waddr = copy_addr_r;
      b_wdata = s_rdata_a;
    end else if (emit_load) begin
      b_we    = 1'b1;
      b_waddr = rc_addr;
      b_wdata = r_rdata_a;
    end
  end

  // Result store writes: identity at run start, then each new result-by-base product.
  always_comb begin
    r_we    = 1'b0;
    r_waddr = rc_addr;
    r_wdata = (r_r == c_r) ? WIDTH'(1) : '0;
    if (state_r == S_INIT) begin
      r_we = 1'b1;
    end else if (copy_v_r && !sq_r) begin
      r_we    = 1'b1;
      r_waddr = copy_addr_r;
      r_wdata = s_rdata_a;
    end
  end

  assign r_raddr = (state_r == S_EMIT_RD || state_r == S_EMIT_WAIT) ? rc_addr : rk_addr;
  assign mac_a   = sq_r ? b_rdata_a : r_rdata_a;

  mpe_ram #(
    .WIDTH (WIDTH),
    .DEPTH (CELLS)
  ) u_base_ram (
    .clk     (clk),
    .we      (b_we),
    .waddr   (b_waddr),
    .wdata   (b_wdata),
    .raddr_a (rk_addr),
    .rdata_a (b_rdata_a),
    .raddr_b (kc_addr),
    .rdata_b (b_rdata_b)
  );

  mpe_ram #(
    .WIDTH (WIDTH),
    .DEPTH (CELLS)
  ) u_result_ram (
    .clk     (clk),
    .we      (r_we),
    .waddr   (r_waddr),
    .wdata   (r_wdata),
    .raddr_a (r_raddr),
    .rdata_a (r_rdata_a),
    .raddr_b (r_raddr),
    .rdata_b ()
  );

  mpe_ram #(
    .WIDTH (WIDTH),
    .DEPTH (CELLS)
  ) u_scratch_ram (
    .clk     (clk),
    .we      (mac_wr_en),
    .waddr   (mac_wr_addr),
    .wdata   (mac_wr_data),
    .raddr_a (rc_addr),
    .rdata_a (s_rdata_a),
    .raddr_b (rc_addr),
    .rdata_b ()
  );

  mpe_mac #(
    .WIDTH (WIDTH),
    .AW    (AW)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_in  (tag_r),
    .addr_in (tag_addr_r),
    .a_in    (mac_a),
    .b_in    (b_rdata_b),
    .busy    (mac_busy),
    .wr_en   (mac_wr_en),
    .wr_addr (mac_wr_addr),
    .wr_data (mac_wr_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{mpe_pkg::OUT_PAD_W{1'b0}}, out_value_r, out_col_r, out_row_r};

`ifndef SYNTHESIS
  // Dot products land in the scratch store only while a multiply is running.
  a_mac_write_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mac_wr_en |-> (state_r == S_MUL || state_r == S_DRAIN))
    else $error("scratch write outside a multiply");

  // Copying out of the scratch store starts only once the pipeline is empty.
  a_copy_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    copy_v_r |-> (!mac_busy && !tag_r.valid))
    else $error("scratch copy while products are in flight");

  // An idle block has no work left in its datapath.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!mac_busy && !tag_r.valid && !copy_v_r))
    else $error("datapath active while idle");
`endif

endmodule

// ===== tb/sv/matrix_power_engine_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_power_engine_unit_tb: self-checking bench for the matrix power engine
// Streams element loads and power runs into the block, computes every matrix
// power on the side by square-and-multiply with 32-bit wrapping arithmetic,
// and checks each emitted element in order against it. Both stream sides
// stall at random, with a long output hold-off and a full drain along the way.
// ----------------------------------------------------------------------------
module matrix_power_engine_unit_tb;

  localparam int MAT_DIM        = 8;
  localparam int ELEM_W         = 32;
  localparam int CELLS          = MAT_DIM * MAT_DIM;
  localparam int RANDOM_ITEMS   = 93;
  localparam int RX_HOLD_CYCLES = 4000;
  localparam int DRAIN_CYCLES   = 200;

  typedef struct {
    logic        op;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] val;
    logic [62:0] expo;
    bit          hold_rx;    // start the long output hold-off when accepted
    bit          wait_idle;  // offer only once every result has come back
    int          phase;
  } mpe_item_t;

  typedef struct packed {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] value;
    logic        last;
  } elem_t;

  logic                               clk;
  logic                               rst_n;
  logic [mpe_pkg::IN_TDATA_W-1:0]     in_tdata;
  logic                               in_tuser;
  logic                               in_tvalid;
  logic                               in_tready;
  logic [mpe_pkg::OUT_TDATA_W-1:0]    out_tdata;
  logic                               out_tlast;
  logic                               out_tvalid;
  logic                               out_tready;

  mpe_item_t   pending_items[$];
  elem_t       expected_elems[$];
  mpe_item_t   drv_item;
  bit          in_taken;
  int          stim_phase;
  bit          rx_hold_req;
  bit          rx_hold_seen;
  int          rx_hold_left;
  int          mismatch_count;

  // Side copy of the block's matrices.
  logic [31:0] pow_base [CELLS];
  logic [31:0] pow_acc  [CELLS];
  logic [31:0] pow_tmp  [CELLS];

  matrix_power_engine_unit #(
    .DIM   (MAT_DIM),
    .WIDTH (ELEM_W)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("matrix_power_engine_unit: mismatch");
    $finish;
  end

  function automatic int idle_pct(input int ph, input bit rx_side);
    case (ph)
      0:       return rx_side ? 81 : 37;
      1:       return rx_side ? 37 : 81;
      default: return 0;
    endcase
  endfunction

  function automatic mpe_item_t mk_item(input logic op, input logic [2:0] row,
                                        input logic [2:0] col, input logic [31:0] val,
                                        input logic [62:0] expo, input int ph);
    mpe_item_t it;
    it.op        = op;
    it.row       = row;
    it.col       = col;
    it.val       = val;
    it.expo      = expo;
    it.hold_rx   = 1'b0;
    it.wait_idle = 1'b0;
    it.phase     = ph;
    return it;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] ERROR: %s", $realtime, what);
    mismatch_count++;
  endtask

  // One matrix product with wrapping sums: base*base into base when squaring,
  // otherwise acc*base into acc.
  task automatic mat_product(input bit square);
    logic [31:0] sum;
    logic [31:0] lhs;
    for (int r = 0; r < MAT_DIM; r++) begin
      for (int c = 0; c < MAT_DIM; c++) begin
        sum = '0;
        for (int k = 0; k < MAT_DIM; k++) begin
          lhs = square ? pow_base[r*MAT_DIM+k] : pow_acc[r*MAT_DIM+k];
          sum = sum + lhs * pow_base[k*MAT_DIM+c];
        end
        pow_tmp[r*MAT_DIM+c] = sum;
      end
    end
    for (int i = 0; i < CELLS; i++) begin
      if (square) begin
        pow_base[i] = pow_tmp[i];
      end else begin
        pow_acc[i] = pow_tmp[i];
      end
    end
  endtask

  // Applies one accepted item and queues the elements that a run will emit.
  task automatic predict_power(input logic op, input logic [2:0] row,
                               input logic [2:0] col, input logic [31:0] val,
                               input logic [62:0] expo);
    logic [62:0] exp_left;
    elem_t       el;
    if (op == mpe_pkg::OP_LOAD) begin
      if (row < MAT_DIM && col < MAT_DIM) begin
        pow_base[row*MAT_DIM+col] = val;
      end
    end else begin
      for (int r = 0; r < MAT_DIM; r++) begin
        for (int c = 0; c < MAT_DIM; c++) begin
          pow_acc[r*MAT_DIM+c] = (r == c) ? 32'd1 : 32'd0;
        end
      end
      exp_left = expo;
      while (exp_left != 0) begin
        if (exp_left[0]) mat_product(1'b0);
        exp_left = exp_left >> 1;
        if (exp_left != 0) mat_product(1'b1);
      end
      // The result becomes the base for the next run.
      for (int i = 0; i < CELLS; i++) begin
        pow_base[i] = pow_acc[i];
      end
      for (int r = 0; r < MAT_DIM; r++) begin
        for (int c = 0; c < MAT_DIM; c++) begin
          el.row   = r[2:0];
          el.col   = c[2:0];
          el.value = pow_acc[r*MAT_DIM+c];
          el.last  = (r == MAT_DIM - 1 && c == MAT_DIM - 1);
          expected_elems.push_back(el);
        end
      end
    end
  endtask

  // Input side: a new item is offered only once the current one was taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_taken) begin
        in_taken = 1'b0;
        if (pending_items.size() != 0 &&
            !(pending_items[0].wait_idle && expected_elems.size() != 0) &&
            $urandom_range(99, 0) >= idle_pct(stim_phase, 1'b0)) begin
          drv_item = pending_items.pop_front();
          in_tdata   <= {3'b000, drv_item.expo, drv_item.val, drv_item.col, drv_item.row};
          in_tuser   <= drv_item.op;
          in_tvalid  <= 1'b1;
          stim_phase <= drv_item.phase;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side: random stalls, plus one long hold-off counted here.
  always @(negedge clk) begin
    if (rx_hold_req && !rx_hold_seen) begin
      rx_hold_seen = 1'b1;
      rx_hold_left = RX_HOLD_CYCLES;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= idle_pct(stim_phase, 1'b1));
    end
  end

  always @(posedge clk) begin
    elem_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        in_taken = 1'b1;
        // The hold-off starts once the marked run is in, so its results back up.
        if (drv_item.hold_rx) rx_hold_req = 1'b1;
        predict_power(in_tuser, in_tdata[2:0], in_tdata[5:3], in_tdata[37:6],
                      in_tdata[100:38]);
      end
      if (out_tvalid && out_tready) begin
        if (expected_elems.size() == 0) begin
          report_mismatch($sformatf("unexpected output item, tdata %h", out_tdata));
        end else begin
          want = expected_elems.pop_front();
          if (out_tdata[2:0] !== want.row)
            report_mismatch($sformatf("row %0d, expected %0d", out_tdata[2:0], want.row));
          if (out_tdata[5:3] !== want.col)
            report_mismatch($sformatf("col %0d, expected %0d", out_tdata[5:3], want.col));
          if (out_tdata[37:6] !== want.value)
            report_mismatch($sformatf("value %h at (%0d,%0d), expected %h",
                                      out_tdata[37:6], want.row, want.col, want.value));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("tlast %b at (%0d,%0d), expected %b",
                                      out_tlast, want.row, want.col, want.last));
        end
      end
    end
  end

  initial begin
    mpe_item_t   it;
    int          added;
    int          n_loads;
    int          big_left;
    int          ph;
    logic [62:0] expo;
    logic [31:0] val;

    rst_n          = 1'b0;
    in_tdata       = '0;
    in_tuser       = mpe_pkg::OP_LOAD;
    in_tvalid      = 1'b0;
    out_tready     = 1'b0;
    in_taken       = 1'b0;
    stim_phase     = 0;
    rx_hold_req    = 1'b0;
    rx_hold_seen   = 1'b0;
    rx_hold_left   = 0;
    mismatch_count = 0;

    // A zero power first: it defines every base element without reading any.
    pending_items.push_back(mk_item(mpe_pkg::OP_RUN, 3'd7, 3'd7, 32'hFFFF_FFFF, 63'd0, 0));
    pending_items.push_back(mk_item(mpe_pkg::OP_LOAD, 3'd0, 3'd0, 32'hFFFF_FFFF, 63'd0, 0));
    pending_items.push_back(mk_item(mpe_pkg::OP_LOAD, 3'd7, 3'd7, 32'h0, '1, 0));
    pending_items.push_back(mk_item(mpe_pkg::OP_LOAD, 3'd0, 3'd7, 32'h1, 63'd0, 0));
    pending_items.push_back(mk_item(mpe_pkg::OP_LOAD, 3'd7, 3'd0, 32'h8000_0000, 63'd0, 0));
    pending_items.push_back(mk_item(mpe_pkg::OP_LOAD, 3'd3, 3'd4, 32'h1234_5678, 63'd0, 0));
    pending_items.push_back(mk_item(mpe_pkg::OP_RUN, 3'd0, 3'd0, 32'h0, 63'd1, 0));
    pending_items.push_back(mk_item(mpe_pkg::OP_RUN, 3'd0, 3'd0, 32'h0, 63'd2, 0));
    pending_items.push_back(mk_item(mpe_pkg::OP_RUN, 3'd5, 3'd2, 32'hA5A5_5A5A, '1, 0));
    pending_items.push_back(mk_item(mpe_pkg::OP_LOAD, 3'd1, 3'd2, 32'd3, 63'd0, 0));
    pending_items.push_back(mk_item(mpe_pkg::OP_LOAD, 3'd2, 3'd1, 32'd5, 63'd0, 0));
    pending_items.push_back(mk_item(mpe_pkg::OP_RUN, 3'd0, 3'd0, 32'h0, 63'h4000_0000_0000_0000,
                                    0));
    // Hold the output back while the loads behind this run keep being offered.
    it = mk_item(mpe_pkg::OP_RUN, 3'd0, 3'd0, 32'h0, 63'd3, 0);
    it.hold_rx = 1'b1;
    pending_items.push_back(it);
    pending_items.push_back(mk_item(mpe_pkg::OP_LOAD, 3'd5, 3'd5, 32'd7, 63'd0, 0));
    pending_items.push_back(mk_item(mpe_pkg::OP_LOAD, 3'd6, 3'd0, 32'd9, 63'd0, 0));
    it = mk_item(mpe_pkg::OP_LOAD, 3'd4, 3'd4, 32'd2, 63'd0, 0);
    it.wait_idle = 1'b1;
    pending_items.push_back(it);
    pending_items.push_back(mk_item(mpe_pkg::OP_RUN, 3'd0, 3'd0, 32'h0, 63'd5, 0));

    // Random part: runs of loads closed by a power run, with a few loose loads.
    added    = 0;
    big_left = 2;
    while (added < RANDOM_ITEMS) begin
      n_loads = $urandom_range(8, 0);
      for (int i = 0; i < n_loads; i++) begin
        ph = (added * 3) / RANDOM_ITEMS;
        case ($urandom_range(3, 0))
          0:       val = 32'h0;
          1:       val = $urandom_range(3, 0);
          2:       val = 32'hFFFF_FFFF;
          default: val = $urandom;
        endcase
        pending_items.push_back(mk_item(mpe_pkg::OP_LOAD, 3'($urandom_range(7, 0)),
                                        3'($urandom_range(7, 0)), val,
                                        63'({$urandom, $urandom}), ph));
        added++;
      end
      if ($urandom_range(9, 0) != 0) begin
        ph = (added * 3) / RANDOM_ITEMS;
        case ($urandom_range(99, 0)) inside
          [0:9]:   expo = 63'($urandom_range(2, 0));
          [10:86]: expo = 63'($urandom_range(63, 0));
          [87:96]: expo = 63'($urandom_range(32'h000F_FFFF, 0));
          default: begin
            if (big_left != 0) begin
              expo = 63'({$urandom, $urandom});
              big_left--;
            end else begin
              expo = 63'($urandom_range(63, 0));
            end
          end
        endcase
        pending_items.push_back(mk_item(mpe_pkg::OP_RUN, 3'($urandom_range(7, 0)),
                                        3'($urandom_range(7, 0)), $urandom, expo, ph));
        added++;
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_elems.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("matrix_power_engine_unit: match");
    end else begin
      $display("matrix_power_engine_unit: mismatch");
    end
    $finish;
  end

endmodule
